// ===== rtl/ilir_pkg.sv =====
`timescale 1ns / 1ps

package ilir_pkg;

    // Storage geometry of the list.
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;

    // Field widths of the request and response words.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_SET    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic                   shift_up;
        logic                   shift_down;
        logic [INDEX_W-1:0]     shift_pos;
        logic                   wr_en;
        logic [INDEX_W-1:0]     wr_pos;
        logic [VALUE_WIDTH-1:0] wr_value;
        logic [INDEX_W-1:0]     rd_pos;
    } cell_cmd_t;

endpackage

// ===== rtl/ilir_req_if.sv =====
`timescale 1ns / 1ps

interface ilir_req_if
    import ilir_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [INDEX_W-1:0]     index;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output operation, output index, output value, input ready);
    modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

// ===== rtl/ilir_rsp_if.sv =====
`timescale 1ns / 1ps

interface ilir_rsp_if
    import ilir_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [VALUE_WIDTH-1:0] old_value;
    logic [COUNT_W-1:0]     count;

    modport source (output valid, output status, output old_value, output count, input ready);
    modport sink   (input valid, input status, input old_value, input count, output ready);
endinterface

// ===== rtl/ilir_cell.sv =====
`timescale 1ns / 1ps

module ilir_cell
    import ilir_pkg::*;
(
    input  logic                   clk,
    input  logic [INDEX_W-1:0]     position,
    input  cell_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    // A direct write wins over a shift, so an insert drops its new value into
    // the cell at the index while the cells above it take their lower neighbor.
    always_comb
    begin
        value_next = value_reg;
        if (cmd.shift_up && (position > cmd.shift_pos))
        begin
            value_next = left_value;
        end
        if (cmd.shift_down && (position >= cmd.shift_pos))
        begin
            value_next = right_value;
        end
        if (cmd.wr_en && (position == cmd.wr_pos))
        begin
            value_next = cmd.wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign rd_data = (position == cmd.rd_pos) ? value_reg : '0;

endmodule

// ===== rtl/ilir_ctrl.sv =====
`timescale 1ns / 1ps

module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [OP_W-1:0]        req_operation,
    input  logic [INDEX_W-1:0]     req_index,
    input  logic [VALUE_WIDTH-1:0] req_value,
    input  logic [VALUE_WIDTH-1:0] sel_value,
    output cell_cmd_t              cmd,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_W-1:0]    rsp_status,
    output logic [VALUE_WIDTH-1:0] rsp_old_value,
    output logic [COUNT_W-1:0]     rsp_count
);

    logic [COUNT_W-1:0]     capacity_reg;
    logic [COUNT_W-1:0]     capacity_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [VALUE_WIDTH-1:0] old_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    logic                   accept;
    logic [COUNT_W-1:0]     limit;
    logic                   full;
    status_t                status;
    logic [VALUE_WIDTH-1:0] old_value;
    logic [INDEX_W-1:0]     count_idx;

    assign req_ready = !out_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // The usable limit saturates at the number of cells.
    assign limit     = (capacity_reg > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : capacity_reg;
    assign full      = (count_reg >= limit);
    assign count_idx = INDEX_W'(count_reg);

    always_comb
    begin
        cmd            = '0;
        cmd.rd_pos     = req_index;
        cmd.shift_pos  = req_index;
        cmd.wr_value   = req_value;
        status         = ST_OK;
        old_value      = '0;
        count_next     = count_reg;
        case (op_t'(req_operation))
            OP_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.wr_en  = accept;
                    cmd.wr_pos = count_idx;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (req_index > count_idx)
                begin
                    status = ST_BAD_INDEX;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.shift_up = accept;
                    cmd.wr_en    = accept;
                    cmd.wr_pos   = req_index;
                    count_next   = count_reg + COUNT_W'(1);
                end
            end
            OP_SET:
            begin
                if (req_index >= count_idx)
                begin
                    status = ST_BAD_INDEX;
                end
                else
                begin
                    cmd.wr_en  = accept;
                    cmd.wr_pos = req_index;
                    old_value  = sel_value;
                end
            end
            OP_REMOVE:
            begin
                if (req_index >= count_idx)
                begin
                    status = ST_BAD_INDEX;
                end
                else
                begin
                    cmd.shift_down = accept;
                    old_value      = sel_value;
                    count_next     = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                status = ST_BAD_INDEX;
            end
        endcase
    end

    always_comb
    begin
        capacity_next  = cfg_we ? cfg_wdata : capacity_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= COUNT_W'(64);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status;
            old_reg       <= old_value;
            out_count_reg <= count_next;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = status_reg;
    assign rsp_old_value = old_reg;
    assign rsp_count     = out_count_reg;

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
`timescale 1ns / 1ps

// Indexed list with append, insert, set and remove.
//
// Requests arrive on the req channel as words of operation, index and value;
// each accepted request produces exactly one response word on the rsp
// channel carrying the status, the old value and the entry count afterward.
// The capacity register is written through cfg_we and cfg_wdata; the user must
// keep the block idle then (not enforced). It resets to 64, clamped to DEPTH.
//
// The entries live in a row of cells, one per position. A single broadcast
// command tells every cell in the same cycle whether to hold, take its lower
// neighbor (insert), take its upper neighbor (remove) or load the new value.
// Every operation therefore finishes on acceptance: the response is valid the
// cycle after acceptance, and a new request can be taken every cycle.
// The response sits in an output register; while it waits, the block keeps
// accepting as long as the receiver takes the word in the same cycle, and it
// stalls only when the held word is not taken. Reset empties the list and
// drops any pending response; cell contents are not cleared.
module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    ilir_req_if.sink           req,
    ilir_rsp_if.source         rsp
);

    cell_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_rd    [DEPTH];
    logic [VALUE_WIDTH-1:0] sel_value;

    ilir_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_operation (req.operation),
        .req_index     (req.index),
        .req_value     (req.value),
        .sel_value     (sel_value),
        .cmd           (cmd),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_status    (rsp.status),
        .rsp_old_value (rsp.old_value),
        .rsp_count     (rsp.count)
    );

    // The cells form a chain: each sees the value of the cell below and of
    // the cell above. The ends of the chain see zero, which only ever lands
    // in positions at or beyond the count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        ilir_cell u_cell (
            .clk         (clk),
            .position    (INDEX_W'(i)),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .rd_data     (cell_rd[i])
        );
    end

    // Only the addressed cell drives a nonzero read word, so the old value
    // is the OR of all cell read words.
    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_value = sel_value | cell_rd[i];
        end
    end

endmodule

// ===== test/indexed_list_insert_remove_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the indexed list. A shadow copy of the list runs beside the
// block: every request word accepted by the block is applied to the shadow,
// which queues the reply word the block must produce. Every reply word taken
// from the block is checked against the oldest queued reply.
module indexed_list_insert_remove_tb;
    import ilir_pkg::*;

    // One reply word as the shadow predicts it.
    typedef struct packed {
        status_t                status;
        logic [VALUE_WIDTH-1:0] old_value;
        logic [COUNT_W-1:0]     count;
    } list_reply_t;

    // Shadow of the list contents, the entry count and the capacity limit,
    // together with the queue of reply words still owed by the block.
    class list_shadow;
        logic [VALUE_WIDTH-1:0] cells[DEPTH];
        int unsigned            held;
        int unsigned            cap_limit;
        list_reply_t            awaited_replies[$];
        int unsigned            mismatches;

        function new();
            held       = 0;
            cap_limit  = 64;
            mismatches = 0;
        endfunction

        // The block clamps the capacity register to its number of cells.
        function void set_capacity(logic [COUNT_W-1:0] cap);
            cap_limit = (cap > DEPTH) ? DEPTH : cap;
        endfunction

        function int unsigned pending();
            return awaited_replies.size();
        endfunction

        // Apply one accepted request word and queue the reply it causes.
        function void take_request(op_t op, logic [INDEX_W-1:0] idx,
                                   logic [VALUE_WIDTH-1:0] val);
            list_reply_t r;
            r.status    = ST_OK;
            r.old_value = '0;
            case (op)
                OP_APPEND:
                begin
                    if (held >= cap_limit)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        cells[held] = val;
                        held++;
                    end
                end
                OP_INSERT:
                begin
                    // The index check comes before the fullness check.
                    if (idx > held)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else if (held >= cap_limit)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        for (int j = held; j > idx; j--)
                        begin
                            cells[j] = cells[j-1];
                        end
                        cells[idx] = val;
                        held++;
                    end
                end
                OP_SET:
                begin
                    if (idx >= held)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        r.old_value = cells[idx];
                        cells[idx]  = val;
                    end
                end
                default:
                begin
                    if (idx >= held)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        r.old_value = cells[idx];
                        for (int j = idx; j + 1 < held; j++)
                        begin
                            cells[j] = cells[j+1];
                        end
                        held--;
                    end
                end
            endcase
            r.count = COUNT_W'(held);
            awaited_replies.push_back(r);
        endfunction

        // Compare one accepted reply word with the oldest queued reply.
        function void check_reply(logic [STATUS_W-1:0] st, logic [VALUE_WIDTH-1:0] old,
                                  logic [COUNT_W-1:0] cnt);
            list_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: reply word with none pending: status %0d old %h count %0d",
                             $realtime, st, old, cnt);
                end
                mismatches++;
                return;
            end
            want = awaited_replies.pop_front();
            if (st !== want.status || old !== want.old_value || cnt !== want.count)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: reply mismatch: status %0d/%0d old %h/%h count %0d/%0d",
                             $realtime, want.status, st, want.old_value, old,
                             want.count, cnt);
                    $display("    (values shown as expected/actual)");
                end
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    ilir_req_if req_ch ();
    ilir_rsp_if rsp_ch ();

    list_shadow shadow = new();

    // When this is low, neither side inserts idle or stall bursts.
    bit idling_on = 1'b1;

    indexed_list_insert_remove uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Reply side: every reply word taken at a clock edge is checked. Signals
    // are sampled at the edge, before any nonblocking update of that edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            shadow.check_reply(rsp_ch.status, rsp_ch.old_value, rsp_ch.count);
        end
    end

    // Reply side back-pressure: ready drops in bursts now and then,
    // separated by stretches in which it stays high.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
    end

    // Present one request word and hold it until the block accepts it. The
    // shadow takes the word at the edge of acceptance, so the entry count it
    // holds is exact when the next word is chosen.
    task automatic send_request(op_t op, logic [INDEX_W-1:0] idx,
                                logic [VALUE_WIDTH-1:0] val);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.index     <= idx;
        req_ch.value     <= val;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        shadow.take_request(op, idx, val);
    endtask

    // Stop sending and wait until every reply word has come back. Each word
    // causes exactly one reply, so a short pause afterward is plenty.
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (shadow.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Write the capacity register; the block must be idle.
    task automatic write_capacity(logic [COUNT_W-1:0] cap);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.set_capacity(cap);
    endtask

    // Data values lean toward the extremes now and then.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random words in segments that either grow or shrink the list, so that
    // it swings between empty and full. Most indices are in range for the
    // current count; about one word in ten uses any 7-bit index.
    task automatic run_random(int unsigned n_words);
        int unsigned sent;
        int unsigned seg_left;
        bit growing;
        int unsigned roll;
        op_t op;
        logic [INDEX_W-1:0] idx;
        sent     = 0;
        seg_left = 0;
        growing  = 1'b1;
        while (sent < n_words)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 100);
                growing  = (shadow.held == 0) ? 1'b1 :
                           (shadow.held >= shadow.cap_limit) ? 1'b0 : 1'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (growing)
            begin
                op = (roll < 45) ? OP_APPEND : (roll < 75) ? OP_INSERT :
                     (roll < 90) ? OP_SET : OP_REMOVE;
            end
            else
            begin
                op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT :
                     (roll < 40) ? OP_SET : OP_REMOVE;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                idx = INDEX_W'($urandom_range(0, 127));
            end
            else if (op == OP_INSERT)
            begin
                idx = INDEX_W'($urandom_range(0, shadow.held));
            end
            else if (shadow.held != 0)
            begin
                idx = INDEX_W'($urandom_range(0, shadow.held - 1));
            end
            else
            begin
                idx = INDEX_W'($urandom_range(0, 127));
            end
            send_request(op, idx, pick_value());
            sent++;
            seg_left--;
        end
    endtask

    initial
    begin
        // Every input is known from time zero; reset starts asserted.
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_APPEND;
        req_ch.index     = '0;
        req_ch.value     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset capacity of 64. Operations on the
        // empty list must all report a bad index, except an insert at 0.
        send_request(OP_REMOVE, 0, 32'h1234_5678);
        send_request(OP_SET, 0, 32'h1111_1111);
        send_request(OP_INSERT, 1, 32'h2222_2222);
        send_request(OP_INSERT, 0, 32'hFFFF_FFFF);
        send_request(OP_APPEND, 127, 32'h0000_0000);
        send_request(OP_APPEND, 0, 32'hA5A5_A5A5);
        // Insert exactly at the count is an append; one above it is refused.
        send_request(OP_INSERT, 3, 32'h5A5A_5A5A);
        send_request(OP_INSERT, 5, 32'hDEAD_BEEF);
        send_request(OP_INSERT, 1, 32'h0000_0001);
        send_request(OP_SET, 0, 32'h8000_0000);
        send_request(OP_SET, 4, 32'h7FFF_FFFF);
        send_request(OP_SET, 5, 32'hCAFE_F00D);
        send_request(OP_SET, 127, 32'hCAFE_F00D);
        send_request(OP_REMOVE, 127, 32'h0);
        send_request(OP_INSERT, 127, 32'h0BAD_0BAD);
        send_request(OP_REMOVE, 2, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 3, 32'h0);

        // Capacity zero: appends and in-range inserts report full, an
        // insert past the count still reports a bad index first, while set
        // and remove keep working on the entries already held.
        write_capacity(0);
        send_request(OP_APPEND, 0, 32'h1357_9BDF);
        send_request(OP_INSERT, 0, 32'h2468_ACE0);
        send_request(OP_INSERT, 64, 32'h2468_ACE0);
        send_request(OP_SET, 1, 32'h0F0F_0F0F);
        send_request(OP_REMOVE, 0, 32'h0);

        // Random phases through several capacities: the smallest nonzero ones, a
        // value above the cell count that must saturate, zero, one in the middle
        // and the full 64.
        write_capacity(1);
        run_random(250);
        write_capacity(127);
        run_random(400);
        write_capacity(2);
        run_random(200);
        write_capacity(0);
        run_random(60);
        write_capacity(COUNT_W'($urandom_range(3, 63)));
        run_random(300);
        write_capacity(64);
        run_random(350);

        // Last stretch runs at full rate on both sides. A stall burst that
        // began before idling was switched off is allowed to run out first.
        drain_replies();
        idling_on = 1'b0;
        while (!rsp_ch.ready)
        begin
            @(posedge clk);
        end
        run_random(350);

        drain_replies();
        repeat (5) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
        begin
            $display("indexed_list_insert_remove_tb passed");
        end
        else
        begin
            $display("indexed_list_insert_remove_tb failed");
        end
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("indexed_list_insert_remove_tb failed");
        $finish;
    end

endmodule
